>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> sv/ctpc_pkg.sv
// ----------------------------------------------------------------------------
// ctpc_pkg
// sizes, codes and types shared by the credential table blocks
// ----------------------------------------------------------------------------
package ctpc_pkg;

    localparam int MAX_USERS = 16;
    localparam int ID_BYTES  = 5;
    localparam int PIN_CHARS = 4;

    localparam int ID_W    = 8 * ID_BYTES;
    localparam int PIN_W   = 8 * PIN_CHARS;
    localparam int SLOT_W  = $clog2(MAX_USERS);
    localparam int CNT_W   = $clog2(MAX_USERS + 1);
    localparam int ACT_W   = 3;
    localparam int LIMIT_W = 8;

    localparam logic [ACT_W-1:0] ACT_VERIFY  = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_ADD     = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_REMOVE  = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_EDIT    = ACT_W'(3);
    localparam logic [ACT_W-1:0] ACT_UNBLOCK = ACT_W'(4);

    localparam logic [LIMIT_W-1:0] DENY_LIMIT_RESET = LIMIT_W'(3);

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_DENIED    = 3'd1,
        ST_BLOCKED   = 3'd2,
        ST_DONE      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic             active;
        logic [PIN_W-1:0] pin;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

>>> sv/ctpc_in_if.sv
// ----------------------------------------------------------------------------
// ctpc_in_if
// request channel: action, card id and pin with valid/ready
// ----------------------------------------------------------------------------
interface ctpc_in_if;
    import ctpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  card_id;
    logic [PIN_W-1:0] pin_code;

    modport source (output valid, output action, output card_id, output pin_code,
                    input ready);
    modport sink   (input valid, input action, input card_id, input pin_code,
                    output ready);
endinterface

>>> sv/ctpc_out_if.sv
// ----------------------------------------------------------------------------
// ctpc_out_if
// response channel: status, slot and user count with valid/ready
// ----------------------------------------------------------------------------
interface ctpc_out_if;
    import ctpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  user_count;

    modport source (output valid, output status, output slot_index, output user_count,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input user_count,
                    output ready);
endinterface

>>> sv/ctpc_ram.sv
// ----------------------------------------------------------------------------
// ctpc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ctpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/ctpc_ctrl.sv
// ----------------------------------------------------------------------------
// ctpc_ctrl
// table sequencer: lookup walk, read-modify-write and compaction on the ram
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctpc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    ctpc_in_if.sink                       in_ch,
    input  logic [ctpc_pkg::LIMIT_W-1:0]  deny_limit,
    output ctpc_pkg::result_t             res,
    input  logic                          res_take,
    output logic                          mem_we,
    output logic [ctpc_pkg::SLOT_W-1:0]   mem_waddr,
    output ctpc_pkg::entry_t              mem_wdata,
    output logic                          mem_re,
    output logic [ctpc_pkg::SLOT_W-1:0]   mem_raddr,
    input  ctpc_pkg::entry_t              mem_rdata
);
    import ctpc_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PIN_W-1:0]  pin_reg, pin_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LIMIT_W-1:0] deny_reg, deny_next;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [CNT_W-1:0]   idx_inc;
    logic [LIMIT_W-1:0] deny_inc;
    logic               deny_hit;
    logic               id_match;
    logic               pin_ok;

    assign idx_inc  = idx_reg + 1'b1;
    assign deny_inc = deny_reg + 1'b1;
    assign deny_hit = (deny_inc >= deny_limit);
    assign id_match = (mem_rdata.id == id_reg);
    assign pin_ok   = mem_rdata.active && (mem_rdata.pin == pin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            deny_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            deny_reg  <= deny_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        pin_reg    <= pin_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        pin_next    = pin_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        deny_next   = deny_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[SLOT_W-1:0];
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg[SLOT_W-1:0];
        in_ch.ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    act_next    = in_ch.action;
                    id_next     = in_ch.card_id;
                    pin_next    = in_ch.pin_code;
                    idx_next    = '0;
                    status_next = ST_NOT_FOUND;
                    slot_next   = '0;
                    case (in_ch.action)
                        ACT_VERIFY, ACT_REMOVE, ACT_EDIT, ACT_UNBLOCK:
                        begin
                            state_next = S_RD;
                        end
                        ACT_ADD:
                        begin
                            state_next = S_RESP;
                            if (count_reg >= CNT_W'(MAX_USERS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // append at the first free slot
                                mem_we           = 1'b1;
                                mem_waddr        = count_reg[SLOT_W-1:0];
                                mem_wdata.active = 1'b1;
                                mem_wdata.pin    = in_ch.pin_code;
                                mem_wdata.id     = in_ch.card_id;
                                count_next       = count_reg + 1'b1;
                                status_next      = ST_DONE;
                                slot_next        = count_reg[SLOT_W-1:0];
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    // walked past the occupied slots: card unknown
                    state_next = S_RESP;
                    if (act_reg == ACT_VERIFY)
                    begin
                        status_next = ST_DENIED;
                        deny_next   = deny_hit ? '0 : deny_inc;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (!id_match)
                begin
                    idx_next   = idx_inc;
                    state_next = S_RD;
                end
                else
                begin
                    slot_next   = idx_reg[SLOT_W-1:0];
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                    case (act_reg)
                        ACT_VERIFY:
                        begin
                            if (pin_ok)
                            begin
                                status_next = ST_GRANTED;
                            end
                            else if (deny_hit)
                            begin
                                deny_next        = '0;
                                mem_we           = 1'b1;
                                mem_wdata.active = 1'b0;
                                status_next      = ST_BLOCKED;
                            end
                            else
                            begin
                                deny_next   = deny_inc;
                                status_next = ST_DENIED;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (idx_inc < count_reg)
                            begin
                                state_next = S_SH_RD;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_EDIT:
                        begin
                            mem_we        = 1'b1;
                            mem_wdata.pin = pin_reg;
                        end
                        ACT_UNBLOCK:
                        begin
                            mem_we           = 1'b1;
                            mem_wdata.active = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                            slot_next   = '0;
                        end
                    endcase
                end
            end

            S_SH_RD:
            begin
                // fetch the next entry for the shift down
                mem_re     = 1'b1;
                mem_raddr  = idx_inc[SLOT_W-1:0];
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_inc;
                if ((idx_inc + 1'b1) < count_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.valid  = (state_reg == S_RESP);
    assign res.status = status_reg;
    assign res.slot   = slot_reg;
    assign res.count  = count_reg;

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(MAX_USERS))
    `ASSERT_CLK(a_cmp_write_in_table, clk, rst_n,
        (mem_we && state_reg == S_CMP) |-> (idx_reg < count_reg))
    `ASSERT_CLK(a_accept_leaves_idle, clk, rst_n,
        (in_ch.valid && in_ch.ready) |=> (state_reg != S_IDLE))
    `ASSERT_CLK(a_resp_holds_state, clk, rst_n,
        (state_reg == S_RESP && !res_take) |=> ($stable(count_reg) && $stable(deny_reg)))
endmodule

>>> sv/credential_table_pin_check.sv
// ----------------------------------------------------------------------------
// credential_table_pin_check
// compacted card/pin table with verify, add, remove, edit and unblock
// ----------------------------------------------------------------------------
// usage
//   in_ch  : request items (action, card_id, pin_code), valid/ready
//   out_ch : one response item per request (status, slot_index, user_count)
//   cfg_we / cfg_wdata : write of deny_limit, only while the block is idle
// operation
//   one request at a time; table entries live in a 16-deep ram with a
//   registered read, so a lookup walks the slots with a read state and a
//   compare state per slot, stopping at the match or at the user count:
//   verify / edit / unblock : lookup, any update at the match, response
//   remove                  : lookup, then a read and write per shifted entry
//   add and undefined actions : no lookup, straight to the response
//   worst case is a lookup that misses in a full table
// reset
//   table empty, denial counter zero, deny_limit back to 3; ram contents
//   are not cleared, only occupied slots are ever read
// stall
//   the response sits in an output register; the next request is taken while
//   it waits, and that request's response is held until the register frees
// ----------------------------------------------------------------------------
module credential_table_pin_check (
    input  logic                         clk,
    input  logic                         rst_n,
    ctpc_in_if.sink                      in_ch,
    ctpc_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic [ctpc_pkg::LIMIT_W-1:0] cfg_wdata
);
    import ctpc_pkg::*;

    // configuration register
    logic [LIMIT_W-1:0] deny_limit_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    result_t res;
    logic    res_take;

    logic             mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic [$bits(entry_t)-1:0] mem_rdata_bits;
    entry_t           mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deny_limit_reg <= DENY_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            deny_limit_reg <= cfg_wdata;
        end
    end

    // output slot is free when empty or being drained this cycle
    assign res_take = res.valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        if (res_take)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res.status;
            out_slot_next   = res.slot;
            out_count_next  = res.count;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.slot_index = out_slot_reg;
    assign out_ch.user_count = out_count_reg;

    // sequencer: lookup, update and compaction
    ctpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .deny_limit (deny_limit_reg),
        .res        (res),
        .res_take   (res_take),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // entry store: {active, pin, id} per slot
    ctpc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_USERS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata_bits)
    );

    assign mem_rdata = entry_t'(mem_rdata_bits);
endmodule
